// File: src/band_weighted_row_centroid_unit_macros.svh
// Assertion helpers shared by the centroid unit's modules.
// Each expects signals named clock and reset in the scope where it is used.
`ifndef BAND_WEIGHTED_ROW_CENTROID_UNIT_MACROS_SVH
`define BAND_WEIGHTED_ROW_CENTROID_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BWRC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define BWRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bwrc_pkg.sv
package bwrc_pkg;

   // Full angular span split into bands
   localparam int DEGREES = 180;

   // Register field widths
   localparam int ROWS_REG_W = 13;
   localparam int COLS_REG_W = 14;
   localparam int DEG_REG_W  = 8;
   localparam int CSR_DATA_W = 14;
   localparam int CSR_INDEX_W = 2;

   // Register reset values
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 13'd1024;
   localparam logic [COLS_REG_W-1:0] COLS_RESET = 14'd2048;
   localparam logic [DEG_REG_W-1:0]  DEG_RESET  = 8'd1;

   // Band index, and (band + 1) * degrees which stays below twice the span
   localparam int BAND_W = 8;
   localparam int KD_W   = 9;

   // Result format: Q.8 row units
   localparam int CENTROID_W    = 21;
   localparam int CENTROID_FRAC = 8;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_ROWS   = 2'd0,
      CSR_FRAME_COLS   = 2'd1,
      CSR_BAND_DEGREES = 2'd2
   } bwrc_csr_index_type;

   // Position marks that the front attaches to each sample
   typedef struct packed {
      logic row_end;
      logic frame_end;
   } bwrc_mark_type;

   // Status and result of the frame-end divider
   typedef struct packed {
      logic                  done;
      logic                  empty;
      logic [CENTROID_W-1:0] centroid;
   } bwrc_div_result_type;

endpackage

// File: src/band_weighted_row_centroid_unit.sv
// Saliency-weighted vertical centroid of a raster frame split into equal angular bands.
// Samples enter at one per clock while the queue has room; the back end drains the queue only
// while the current row stays in its band, and the band tracker advances one band per cycle
// when a row opens a new band. At frame end a shift-add multiplier (one bit of rows*degrees
// per step, 20 bits at the default MAX_ROWS) and a restoring divider (one numerator bit per
// step, 77 bits at the defaults) produce the result (an empty frame skips both); meanwhile
// the four-entry queue takes up to four more samples before the input stalls, and a finished
// result waits while the output register still holds a stalled beat. A configuration write
// sets a registered restart flag that re-seeds the band tracker. Rows past the last whole
// band add nothing.
module band_weighted_row_centroid_unit #(
   parameter int MAX_ROWS    = 4096,
   parameter int MAX_COLS    = 8192,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [SAMPLE_BITS-1:0]              req_saliency_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bwrc_pkg::CENTROID_W-1:0]     rsp_centroid_row,
   output logic                                rsp_empty_frame,
   input  logic                                csr_we,
   input  logic [bwrc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bwrc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import bwrc_pkg::*;

   localparam int ROWS_W = $clog2(MAX_ROWS + 1);
   localparam int COLS_W = $clog2(MAX_COLS + 1);
   localparam int RD_W   = $clog2(MAX_ROWS * DEGREES + 1);
   localparam int P_W    = SAMPLE_BITS + $clog2(MAX_ROWS * MAX_COLS);
   localparam int W_W    = P_W + BAND_W;
   localparam int Q_W    = SAMPLE_BITS + $bits(bwrc_mark_type);

   logic [ROWS_REG_W-1:0] frame_rows_ff, frame_rows_in;
   logic [COLS_REG_W-1:0] frame_cols_ff, frame_cols_in;
   logic [DEG_REG_W-1:0]  band_deg_ff, band_deg_in;
   logic                  cfg_restart_ff;
   logic [ROWS_W-1:0]     eff_rows;
   logic [COLS_W-1:0]     eff_cols;
   logic [DEG_REG_W-1:0]  eff_deg;

   logic                  q_full, q_push, q_pop, q_valid;
   logic [SAMPLE_BITS-1:0] f_sample, b_sample;
   bwrc_mark_type         f_mark, b_mark;
   logic [Q_W-1:0]        q_out;

   logic                  div_start;
   logic [RD_W-1:0]       div_rd;
   logic [P_W-1:0]        div_plain;
   logic [W_W-1:0]        div_weighted;
   bwrc_div_result_type   div_res;

   // Decode register writes
   always_comb begin
      frame_rows_in = frame_rows_ff;
      frame_cols_in = frame_cols_ff;
      band_deg_in   = band_deg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_ROWS:   frame_rows_in = ROWS_REG_W'(csr_wdata);
            CSR_FRAME_COLS:   frame_cols_in = csr_wdata;
            CSR_BAND_DEGREES: band_deg_in   = DEG_REG_W'(csr_wdata);
            default:          frame_rows_in = frame_rows_ff;
         endcase
      end
   end

   // Re-seed the band tracker after reset and after every write
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff  <= ROWS_RESET;
         frame_cols_ff  <= COLS_RESET;
         band_deg_ff    <= DEG_RESET;
         cfg_restart_ff <= 1'b1;
      end else begin
         frame_rows_ff  <= frame_rows_in;
         frame_cols_ff  <= frame_cols_in;
         band_deg_ff    <= band_deg_in;
         cfg_restart_ff <= csr_we;
      end
   end

   // Clamp registers to their usable ranges
   always_comb begin
      if (frame_rows_ff == '0) begin
         eff_rows = ROWS_W'(1);
      end else if (int'(frame_rows_ff) > MAX_ROWS) begin
         eff_rows = ROWS_W'(MAX_ROWS);
      end else begin
         eff_rows = ROWS_W'(frame_rows_ff);
      end
      if (frame_cols_ff == '0) begin
         eff_cols = COLS_W'(1);
      end else if (int'(frame_cols_ff) > MAX_COLS) begin
         eff_cols = COLS_W'(MAX_COLS);
      end else begin
         eff_cols = COLS_W'(frame_cols_ff);
      end
      if (band_deg_ff == '0) begin
         eff_deg = DEG_REG_W'(1);
      end else if (int'(band_deg_ff) > DEGREES) begin
         eff_deg = DEG_REG_W'(DEGREES);
      end else begin
         eff_deg = band_deg_ff;
      end
   end

   bwrc_front #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_saliency_sample (req_saliency_sample),
      .eff_rows            (eff_rows),
      .eff_cols            (eff_cols),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_sample            (f_sample),
      .q_mark              (f_mark)
   );

   bwrc_fifo #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_mark, f_sample}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_out)
   );

   assign b_sample = q_out[SAMPLE_BITS-1:0];
   assign b_mark   = bwrc_mark_type'(q_out[Q_W-1:SAMPLE_BITS]);

   bwrc_back #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg_restart      (cfg_restart_ff),
      .eff_rows         (eff_rows),
      .eff_deg          (eff_deg),
      .q_valid          (q_valid),
      .q_sample         (b_sample),
      .q_mark           (b_mark),
      .q_pop            (q_pop),
      .div_start        (div_start),
      .div_rd           (div_rd),
      .div_plain        (div_plain),
      .div_weighted     (div_weighted),
      .div_res          (div_res),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_centroid_row (rsp_centroid_row),
      .rsp_empty_frame  (rsp_empty_frame)
   );

   bwrc_div #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .rd           (div_rd),
      .plain_sum    (div_plain),
      .weighted_sum (div_weighted),
      .result       (div_res)
   );

endmodule

// File: src/bwrc_fifo.sv
module bwrc_fifo #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store beat payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/bwrc_front.sv
module bwrc_front #(
   parameter int MAX_ROWS    = 4096,
   parameter int MAX_COLS    = 8192,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [SAMPLE_BITS-1:0]        req_saliency_sample,
   input  logic [$clog2(MAX_ROWS+1)-1:0] eff_rows,
   input  logic [$clog2(MAX_COLS+1)-1:0] eff_cols,
   input  logic                          q_full,
   output logic                          q_push,
   output logic [SAMPLE_BITS-1:0]        q_sample,
   output bwrc_pkg::bwrc_mark_type       q_mark
);

   import bwrc_pkg::*;

   localparam int ROWS_W = $clog2(MAX_ROWS + 1);
   localparam int COLS_W = $clog2(MAX_COLS + 1);
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROWS_W-1:0] row_inc;
   logic [COLS_W-1:0] col_inc;
   logic              row_end, frame_end;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_sample  = req_saliency_sample;

   // Classify the beat by its raster position
   assign col_inc   = COLS_W'(col_ff) + COLS_W'(1);
   assign row_inc   = ROWS_W'(row_ff) + ROWS_W'(1);
   assign row_end   = !(col_inc < eff_cols);
   assign frame_end = row_end && !(row_inc < eff_rows);

   assign q_mark.row_end   = row_end;
   assign q_mark.frame_end = frame_end;

   // Advance raster position on each accepted beat
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (q_push) begin
         if (!row_end) begin
            col_in = COL_W'(col_inc);
         end else begin
            col_in = '0;
            row_in = frame_end ? '0 : ROW_W'(row_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

// File: src/bwrc_div.sv
`include "band_weighted_row_centroid_unit_macros.svh"

module bwrc_div #(
   parameter int MAX_ROWS    = 4096,
   parameter int MAX_COLS    = 8192,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 start,
   input  logic [$clog2(MAX_ROWS*bwrc_pkg::DEGREES+1)-1:0]      rd,
   input  logic [SAMPLE_BITS+$clog2(MAX_ROWS*MAX_COLS)-1:0]     plain_sum,
   input  logic [SAMPLE_BITS+$clog2(MAX_ROWS*MAX_COLS)+bwrc_pkg::BAND_W-1:0]
                                                                weighted_sum,
   output bwrc_pkg::bwrc_div_result_type                        result
);

   import bwrc_pkg::*;

   localparam int RD_W  = $clog2(MAX_ROWS * DEGREES + 1);
   localparam int P_W   = SAMPLE_BITS + $clog2(MAX_ROWS * MAX_COLS);
   localparam int W_W   = P_W + BAND_W;
   localparam int X_W   = RD_W + W_W + CENTROID_FRAC;
   localparam int B_W   = P_W + DEG_REG_W;
   localparam int R_W   = B_W + 1;
   localparam int CNT_W = $clog2(X_W + 1);

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_MUL  = 3'b010,
      DV_DIV  = 3'b100
   } dv_state_type;

   dv_state_type          state_ff, state_in;
   logic [RD_W-1:0]       mplier_ff, mplier_in;
   logic [W_W-1:0]        mcand_ff, mcand_in;
   logic [X_W-1:0]        x_ff, x_in;
   logic [B_W-1:0]        b_ff, b_in;
   logic [B_W-1:0]        rem_ff, rem_in;
   logic [CENTROID_W-1:0] q_ff, q_in;
   logic                  sat_ff, sat_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic                  empty_ff, empty_in;
   logic [CENTROID_W-1:0] centroid_ff, centroid_in;
   logic [X_W-1:0]        x_acc;
   logic [R_W-1:0]        rem_sh;
   logic                  q_bit;

   assign result.done     = done_ff;
   assign result.empty    = empty_ff;
   assign result.centroid = centroid_ff;

   // One shift-add step and one restoring step
   assign x_acc  = (x_ff << 1) + (mplier_ff[RD_W-1] ? X_W'(mcand_ff) : '0);
   assign rem_sh = {rem_ff, x_ff[X_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, b_ff});

   // Sequence: multiply rows*degrees by the weighted sum, then divide; a zero plain sum is reported as an empty frame
   always_comb begin
      state_in    = state_ff;
      mplier_in   = mplier_ff;
      mcand_in    = mcand_ff;
      x_in        = x_ff;
      b_in        = b_ff;
      rem_in      = rem_ff;
      q_in        = q_ff;
      sat_in      = sat_ff;
      cnt_in      = cnt_ff;
      done_in     = 1'b0;
      empty_in    = empty_ff;
      centroid_in = centroid_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               if (plain_sum == '0) begin
                  done_in     = 1'b1;
                  empty_in    = 1'b1;
                  centroid_in = '0;
               end else begin
                  empty_in  = 1'b0;
                  mplier_in = rd;
                  mcand_in  = weighted_sum;
                  x_in      = '0;
                  b_in      = B_W'(plain_sum) * B_W'(DEGREES);
                  cnt_in    = CNT_W'(RD_W);
                  state_in  = DV_MUL;
               end
            end
         end
         DV_MUL: begin
            mplier_in = mplier_ff << 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               x_in     = x_acc << CENTROID_FRAC;
               rem_in   = '0;
               q_in     = '0;
               sat_in   = 1'b0;
               cnt_in   = CNT_W'(X_W);
               state_in = DV_DIV;
            end else begin
               x_in = x_acc;
            end
         end
         DV_DIV: begin
            x_in   = x_ff << 1;
            rem_in = q_bit ? B_W'(rem_sh - {1'b0, b_ff}) : B_W'(rem_sh);
            sat_in = sat_ff | q_ff[CENTROID_W-1];
            q_in   = {q_ff[CENTROID_W-2:0], q_bit};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_in     = 1'b1;
               centroid_in = sat_in ? '1 : q_in;
               state_in    = DV_IDLE;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mplier_ff   <= mplier_in;
      mcand_ff    <= mcand_in;
      x_ff        <= x_in;
      b_ff        <= b_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      sat_ff      <= sat_in;
      cnt_ff      <= cnt_in;
      empty_ff    <= empty_in;
      centroid_ff <= centroid_in;
   end

   `BWRC_ASSERT_IMPLY(a_div_start_idle, start, state_ff == DV_IDLE, "divider started while busy")
   `BWRC_ASSERT_IMPLY(a_div_empty_zero, done_ff && empty_ff, centroid_ff == '0, "empty frame nonzero")

endmodule

// File: src/bwrc_back.sv
`include "band_weighted_row_centroid_unit_macros.svh"

module bwrc_back #(
   parameter int MAX_ROWS    = 4096,
   parameter int MAX_COLS    = 8192,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             cfg_restart,
   input  logic [$clog2(MAX_ROWS+1)-1:0]                    eff_rows,
   input  logic [bwrc_pkg::DEG_REG_W-1:0]                   eff_deg,
   input  logic                                             q_valid,
   input  logic [SAMPLE_BITS-1:0]                           q_sample,
   input  bwrc_pkg::bwrc_mark_type                          q_mark,
   output logic                                             q_pop,
   output logic                                             div_start,
   output logic [$clog2(MAX_ROWS*bwrc_pkg::DEGREES+1)-1:0]  div_rd,
   output logic [SAMPLE_BITS+$clog2(MAX_ROWS*MAX_COLS)-1:0] div_plain,
   output logic [SAMPLE_BITS+$clog2(MAX_ROWS*MAX_COLS)+bwrc_pkg::BAND_W-1:0]
                                                            div_weighted,
   input  bwrc_pkg::bwrc_div_result_type                    div_res,
   output logic                                             rsp_valid,
   input  logic                                             rsp_stall,
   output logic [bwrc_pkg::CENTROID_W-1:0]                  rsp_centroid_row,
   output logic                                             rsp_empty_frame
);

   import bwrc_pkg::*;

   localparam int RD_W = $clog2(MAX_ROWS * DEGREES + 1);
   localparam int N_W  = $clog2(MAX_ROWS * 2 * DEGREES + 1);
   localparam int T_W  = $clog2(MAX_ROWS * DEGREES + 1);
   localparam int P_W  = SAMPLE_BITS + $clog2(MAX_ROWS * MAX_COLS);
   localparam int W_W  = P_W + BAND_W;
   localparam int KP_W = BAND_W + SAMPLE_BITS;

   typedef enum logic [2:0] {
      ST_ACCUM = 3'b001,
      ST_MATH  = 3'b010,
      ST_HOLD  = 3'b100
   } bk_state_type;

   bk_state_type          state_ff, state_in;
   logic [BAND_W-1:0]     k_ff, k_in;
   logic [KD_W-1:0]       kd_ff, kd_in;
   logic [N_W-1:0]        n_ff, n_in;
   logic [T_W-1:0]        t_ff, t_in;
   logic [P_W-1:0]        p_ff, p_in;
   logic [W_W-1:0]        w_ff, w_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CENTROID_W-1:0] centroid_ff;
   logic                  empty_ff;
   logic [RD_W-1:0]       rd;
   logic [KP_W-1:0]       kprod;
   logic [P_W-1:0]        p_new;
   logic [W_W-1:0]        w_new;
   logic                  settled, used, slot_free, load;

   // Band k ends where rows*deg*(k+1) reaches 180*(row+1)
   assign rd      = RD_W'(eff_rows) * RD_W'(eff_deg);
   assign settled = (n_ff >= N_W'(t_ff)) || (kd_ff > KD_W'(DEGREES));
   assign used    = (kd_ff <= KD_W'(DEGREES));

   assign q_pop = (state_ff == ST_ACCUM) && q_valid && settled && !cfg_restart;

   // Accumulate plain and band-weighted sums
   assign kprod = KP_W'(k_ff) * KP_W'(q_sample);
   assign p_new = used ? p_ff + P_W'(q_sample) : p_ff;
   assign w_new = used ? w_ff + W_W'(kprod) : w_ff;

   assign div_start    = q_pop && q_mark.frame_end;
   assign div_rd       = rd;
   assign div_plain    = p_new;
   assign div_weighted = w_new;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign load      = (state_ff == ST_HOLD) && slot_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_centroid_row = centroid_ff;
   assign rsp_empty_frame  = empty_ff;

   // Track the band of the current row, one band per cycle
   always_comb begin
      k_in  = k_ff;
      kd_in = kd_ff;
      n_in  = n_ff;
      t_in  = t_ff;
      if (cfg_restart || div_start) begin
         k_in  = '0;
         kd_in = KD_W'(eff_deg);
         n_in  = N_W'(rd);
      end else if (!settled) begin
         k_in  = k_ff + BAND_W'(1);
         kd_in = kd_ff + KD_W'(eff_deg);
         n_in  = n_ff + N_W'(rd);
      end
      if (q_pop && q_mark.row_end) begin
         t_in = q_mark.frame_end ? T_W'(DEGREES) : t_ff + T_W'(DEGREES);
      end
   end

   // Sums and frame sequencing
   always_comb begin
      p_in         = p_ff;
      w_in         = w_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         p_in = q_mark.frame_end ? '0 : p_new;
         w_in = q_mark.frame_end ? '0 : w_new;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_ACCUM: begin
            if (div_start) begin
               state_in = ST_MATH;
            end
         end
         ST_MATH: begin
            if (div_res.done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         k_ff         <= '0;
         kd_ff        <= '0;
         n_ff         <= '0;
         t_ff         <= T_W'(DEGREES);
         p_ff         <= '0;
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         kd_ff        <= kd_in;
         n_ff         <= n_in;
         t_ff         <= t_in;
         p_ff         <= p_in;
         w_ff         <= w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold result beat payload
   always_ff @(posedge clock) begin
      if (load) begin
         centroid_ff <= div_res.centroid;
         empty_ff    <= div_res.empty;
      end
   end

   `BWRC_ASSERT_IMPLY(a_kd_bound, 1'b1, kd_ff <= KD_W'(2 * DEGREES), "band tracker overran")
   `BWRC_ASSERT_NEXT(a_frame_rewind, div_start, (k_ff == '0) && (t_ff == T_W'(DEGREES)), "no rewind")
   `BWRC_ASSERT_IMPLY(a_done_in_math, div_res.done, state_ff == ST_MATH, "stray divider result")

endmodule
